@@ sv/bal_pkg.sv @@
// Shared types and codes for the bounded array list.
`timescale 1ns / 1ps

package bal_pkg;

  // Default sizes of the list.
  localparam int unsigned DEF_CAPACITY    = 16;
  localparam int unsigned DEF_ENTRY_WIDTH = 32;

  // Fixed field widths of the request and result transfers.
  localparam int unsigned REQ_W    = 3;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_APPEND      = 3'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE_LAST = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INSERT_AT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_ERASE_AT    = 3'd3;
  localparam logic [REQ_W-1:0] REQ_READ_AT     = 3'd4;
  localparam logic [REQ_W-1:0] REQ_READ_FIRST  = 3'd5;
  localparam logic [REQ_W-1:0] REQ_READ_LAST   = 3'd6;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOENTRY = 2'd3;

  // One request transfer.
  typedef struct packed {
    logic [REQ_W-1:0]   req_type;
    logic [POS_W-1:0]   position;
    logic [VALUE_W-1:0] entry_value;
  } bal_in_t;

  // One result transfer.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  read_data;
    logic [COUNT_W-1:0]  entry_count;
  } bal_out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
  } bal_cmd_t;

endpackage

@@ sv/bal_ctrl.sv @@
// Controller state machine for the bounded array list.
`timescale 1ns / 1ps

module bal_ctrl import bal_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  output logic     out_valid,
  output bal_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;

  // Next state: a request is latched in idle and carried out in the following cycle.
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and the registered result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Commands and status towards the ports.
  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;
  assign cmd.load  = (state_r == S_IDLE) && start;
  assign cmd.exec  = (state_r == S_EXEC);

endmodule

@@ sv/bal_datapath.sv @@
// Datapath of the bounded array list: entry cells, count and result register.
`timescale 1ns / 1ps

module bal_datapath import bal_pkg::*; #(
  parameter int unsigned CAPACITY    = DEF_CAPACITY,
  parameter int unsigned ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  bal_cmd_t cmd,
  input  bal_in_t  in_item,
  output bal_out_t out_item
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [ENTRY_WIDTH-1:0] cell_r   [CAPACITY];
  logic [ENTRY_WIDTH-1:0] cell_nxt [CAPACITY];
  logic [CNT_W-1:0]       count_r;
  logic [CNT_W-1:0]       count_nxt;
  bal_in_t                req_r;
  bal_out_t               res_r;
  bal_out_t               res_nxt;

  logic [CMP_W-1:0]       pos_x;
  logic [CMP_W-1:0]       cnt_x;
  logic [CMP_W-1:0]       cap_x;
  logic                   list_full;
  logic                   list_empty;
  logic [ENTRY_WIDTH-1:0] new_word;
  logic [IDX_W-1:0]       rd_idx;
  logic [ENTRY_WIDTH-1:0] rd_word;

  // Operands widened to a common width for the position checks.
  assign pos_x      = CMP_W'(req_r.position);
  assign cnt_x      = CMP_W'(count_r);
  assign cap_x      = CMP_W'(CAPACITY);
  assign list_full  = (count_r == CNT_W'(CAPACITY));
  assign list_empty = (count_r == '0);
  assign new_word   = ENTRY_WIDTH'(req_r.entry_value);

  // One read port: the requested slot, slot zero or the last slot.
  always_comb begin
    case (req_r.req_type)
      REQ_READ_FIRST: rd_idx = '0;
      REQ_READ_LAST:  rd_idx = IDX_W'(count_r - CNT_W'(1));
      default:        rd_idx = IDX_W'(pos_x);
    endcase
  end
  assign rd_word = cell_r[rd_idx];

  // Request decoder: status, read word, new count and the per-cell shifts.
  always_comb begin
    cell_nxt            = cell_r;
    count_nxt           = count_r;
    res_nxt.status      = ST_OK;
    res_nxt.read_data   = '0;
    unique case (req_r.req_type) inside
      REQ_APPEND: begin
        if (list_full) begin
          res_nxt.status = ST_FULL;
        end else begin
          cell_nxt[IDX_W'(count_r)] = new_word;
          count_nxt                 = count_r + CNT_W'(1);
        end
      end
      REQ_REMOVE_LAST: begin
        if (list_empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_INSERT_AT: begin
        if (pos_x >= cap_x) begin
          res_nxt.status = ST_NOENTRY;
        end else if (list_full) begin
          res_nxt.status = ST_FULL;
        end else if (pos_x > cnt_x) begin
          res_nxt.status = ST_NOENTRY;
        end else begin
          // Every cell above the position takes its lower neighbour.
          for (int i = 0; i < CAPACITY; i++) begin
            if (CMP_W'(i) == pos_x) begin
              cell_nxt[i] = new_word;
            end else if ((i > 0) && (CMP_W'(i) > pos_x)) begin
              cell_nxt[i] = cell_r[(i > 0) ? i - 1 : 0];
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_ERASE_AT: begin
        if ((pos_x >= cap_x) || (pos_x >= cnt_x)) begin
          res_nxt.status = ST_NOENTRY;
        end else begin
          // Every cell from the position up takes its upper neighbour.
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (CMP_W'(i) >= pos_x) begin
              cell_nxt[i] = cell_r[i + 1];
            end
          end
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_READ_AT: begin
        if ((pos_x < cap_x) && (pos_x < cnt_x)) begin
          res_nxt.read_data = VALUE_W'(rd_word);
        end else begin
          res_nxt.status = ST_NOENTRY;
        end
      end
      REQ_READ_FIRST, REQ_READ_LAST: begin
        if (list_empty) begin
          res_nxt.status = ST_EMPTY;
        end else begin
          res_nxt.read_data = VALUE_W'(rd_word);
        end
      end
      default: begin
      end
    endcase
    res_nxt.entry_count = COUNT_W'(count_nxt);
  end

  // Entry count is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  // Request latch, entry cells and result register carry payload only.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_item;
    end
    if (cmd.exec) begin
      cell_r <= cell_nxt;
      res_r  <= res_nxt;
    end
  end

  assign out_item = res_r;

endmodule

@@ sv/bounded_array_list_core.sv @@
// Top level of the bounded array list.
`timescale 1ns / 1ps

// A request transfer is taken when start is high and busy is low. The block then
// raises busy for one cycle while, for an insert or erase, the entry cells shift in
// parallel, and in the cycle after that shows the result on out_item with out_valid
// high for exactly one cycle. The request latch and the result register lie around
// the single execute step; a new request may be started in the same cycle that the
// previous result is shown. The receiver cannot stall: each result must be taken
// in the cycle that out_valid marks.
module bounded_array_list_core import bal_pkg::*; #(
  parameter int unsigned CAPACITY    = DEF_CAPACITY,
  parameter int unsigned ENTRY_WIDTH = DEF_ENTRY_WIDTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  bal_in_t  in_item,
  output logic     out_valid,
  output bal_out_t out_item
);

  bal_cmd_t cmd;

  // Sequencing of each request.
  bal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Entry cells, count and result.
  bal_datapath #(
    .CAPACITY    (CAPACITY),
    .ENTRY_WIDTH (ENTRY_WIDTH)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_item  (in_item),
    .out_item (out_item)
  );

endmodule

@@ dv/bounded_array_list_core_tb.sv @@
// Self-checking testbench for the bounded array list core.
`timescale 1ns / 1ps

module bounded_array_list_core_tb;
  import bal_pkg::*;

  // Sizes and limits of the bench.
  localparam int unsigned LIST_CAP    = DEF_CAPACITY;
  localparam int unsigned CYCLE_LIMIT = 100000;
  localparam int unsigned BURST_LEN   = 40;
  localparam int unsigned PHASE_ITEMS = 175;

  // The one request code the block leaves unused.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 3'd7;

  logic     clk     = 1'b0;
  logic     rst_n   = 1'b0;
  logic     start   = 1'b0;
  bal_in_t  in_item = '0;
  logic     busy;
  logic     out_valid;
  bal_out_t out_item;

  // Requests waiting to be driven and results waiting to be checked.
  bal_in_t  request_queue[$];
  bal_out_t result_queue[$];

  // Shadow copy of the list, updated as each request transfer is taken.
  logic [VALUE_W-1:0] shadow_entries[LIST_CAP];
  int unsigned        shadow_len = 0;

  // Rough count used only to steer the random positions towards valid ones.
  int unsigned  guess_len    = 0;
  int unsigned  idle_pct     = 0;
  int unsigned  issued_cnt   = 0;
  int unsigned  accepted_cnt = 0;
  int unsigned  cycle_cnt    = 0;
  bit           failed       = 1'b0;

  bounded_array_list_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the result it should give.
  function automatic bal_out_t apply_request(bal_in_t req);
    bal_out_t    res;
    int unsigned pos;
    int unsigned k;
    res        = '0;
    res.status = ST_OK;
    pos        = req.position;
    case (req.req_type)
      REQ_APPEND: begin
        if (shadow_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else begin
          shadow_entries[shadow_len] = req.entry_value;
          shadow_len++;
        end
      end
      REQ_REMOVE_LAST: begin
        if (shadow_len == 0) res.status = ST_EMPTY;
        else shadow_len--;
      end
      REQ_INSERT_AT: begin
        if (pos >= LIST_CAP) begin
          res.status = ST_NOENTRY;
        end else if (shadow_len >= LIST_CAP) begin
          res.status = ST_FULL;
        end else if (pos > shadow_len) begin
          res.status = ST_NOENTRY;
        end else begin
          // Later entries move up one slot; inserting at the count is an append.
          for (k = shadow_len; k > pos; k--) shadow_entries[k] = shadow_entries[k-1];
          shadow_entries[pos] = req.entry_value;
          shadow_len++;
        end
      end
      REQ_ERASE_AT: begin
        if (pos >= shadow_len) begin
          res.status = ST_NOENTRY;
        end else begin
          for (k = pos; k + 1 < shadow_len; k++) shadow_entries[k] = shadow_entries[k+1];
          shadow_len--;
        end
      end
      REQ_READ_AT: begin
        if (pos < shadow_len) res.read_data = shadow_entries[pos];
        else res.status = ST_NOENTRY;
      end
      REQ_READ_FIRST: begin
        if (shadow_len > 0) res.read_data = shadow_entries[0];
        else res.status = ST_EMPTY;
      end
      REQ_READ_LAST: begin
        if (shadow_len > 0) res.read_data = shadow_entries[shadow_len-1];
        else res.status = ST_EMPTY;
      end
      default: begin
        // The unused code does nothing and reports success.
      end
    endcase
    res.entry_count = shadow_len[COUNT_W-1:0];
    return res;
  endfunction

  task automatic queue_request(logic [REQ_W-1:0] code, logic [POS_W-1:0] pos,
                               logic [VALUE_W-1:0] value);
    bal_in_t req;
    req.req_type    = code;
    req.position    = pos;
    req.entry_value = value;
    request_queue = {request_queue, req};
  endtask

  // Build one random request; grow_pct and shrink_pct bias the list length.
  task automatic queue_random(int unsigned grow_pct, int unsigned shrink_pct);
    int unsigned        roll;
    logic [REQ_W-1:0]   code;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      code = REQ_UNUSED;
    end else if (roll < 3 + grow_pct) begin
      code = ($urandom_range(0, 1) == 0) ? REQ_APPEND : REQ_INSERT_AT;
    end else if (roll < 3 + grow_pct + shrink_pct) begin
      code = ($urandom_range(0, 1) == 0) ? REQ_REMOVE_LAST : REQ_ERASE_AT;
    end else begin
      case ($urandom_range(0, 2))
        0:       code = REQ_READ_AT;
        1:       code = REQ_READ_FIRST;
        default: code = REQ_READ_LAST;
      endcase
    end
    // Most positions fall within the current list, the rest anywhere.
    if ($urandom_range(0, 99) < 80) pos = $urandom_range(0, (guess_len > 15) ? 15 : guess_len);
    else pos = $urandom_range(0, 15);
    case ($urandom_range(0, 9))
      0:       value = '0;
      1:       value = '1;
      default: value = $urandom();
    endcase
    if (code == REQ_APPEND || code == REQ_INSERT_AT) begin
      if (guess_len < LIST_CAP) guess_len++;
    end else if (code == REQ_REMOVE_LAST || code == REQ_ERASE_AT) begin
      if (guess_len > 0) guess_len--;
    end
    queue_request(code, pos, value);
  endtask

  // Wait until every queued request has been taken and every result checked.
  task automatic wait_drained();
    while (request_queue.size() != 0 || issued_cnt != accepted_cnt ||
           result_queue.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Driver: present the next request at the falling edge, holding it until taken.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (start && accepted_cnt != issued_cnt) begin
      // The current request has not been taken yet.
    end else if (request_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      start   <= 1'b1;
      in_item <= request_queue.pop_front();
      issued_cnt++;
    end else begin
      start <= 1'b0;
    end
  end

  // Monitor: check each result, then record any request transfer taken at this edge.
  always @(posedge clk) begin
    bal_out_t want;
    if (rst_n) begin
      if (out_valid === 1'b1) begin
        if (result_queue.size() == 0) begin
          $error("result transfer with no request outstanding");
          failed = 1'b1;
        end else begin
          want = result_queue.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, out_item.status);
            failed = 1'b1;
          end
          if (out_item.read_data !== want.read_data) begin
            $error("read_data: expected %08h, actual %08h", want.read_data, out_item.read_data);
            failed = 1'b1;
          end
          if (out_item.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d",
                   want.entry_count, out_item.entry_count);
            failed = 1'b1;
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        result_queue = {result_queue, apply_request(in_item)};
        accepted_cnt++;
      end
    end
  end

  // Watchdog against a hung block.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("** bounded_array_list_core: FAILED **");
      $finish;
    end
  end

  // Stimulus sequence.
  initial begin
    int unsigned phase_idle[4];
    int unsigned ph;
    int unsigned n;
    phase_idle = '{0, 74, 0, 17};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed requests: the empty list, the edges of the fields and each operation.
    queue_request(REQ_READ_FIRST, 4'd0, 32'h0);
    queue_request(REQ_READ_LAST, 4'd0, 32'h0);
    queue_request(REQ_REMOVE_LAST, 4'd0, 32'h0);
    queue_request(REQ_ERASE_AT, 4'd0, 32'h0);
    queue_request(REQ_READ_AT, 4'd0, 32'h0);
    queue_request(REQ_INSERT_AT, 4'd15, 32'h1234_5678);
    queue_request(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF);
    queue_request(REQ_INSERT_AT, 4'd0, 32'h0000_0000);
    queue_request(REQ_APPEND, 4'd15, 32'hFFFF_FFFF);
    queue_request(REQ_INSERT_AT, 4'd1, 32'hA5A5_A5A5);
    queue_request(REQ_INSERT_AT, 4'd0, 32'h5A5A_5A5A);
    queue_request(REQ_READ_AT, 4'd0, 32'h0);
    queue_request(REQ_READ_AT, 4'd3, 32'h0);
    queue_request(REQ_READ_AT, 4'd4, 32'h0);
    queue_request(REQ_READ_FIRST, 4'd9, 32'h0);
    queue_request(REQ_READ_LAST, 4'd9, 32'h0);
    queue_request(REQ_ERASE_AT, 4'd1, 32'h0);
    queue_request(REQ_ERASE_AT, 4'd3, 32'h0);
    queue_request(REQ_ERASE_AT, 4'd0, 32'h0);
    queue_request(REQ_REMOVE_LAST, 4'd0, 32'h0);
    queue_request(REQ_REMOVE_LAST, 4'd0, 32'h0);
    queue_request(REQ_REMOVE_LAST, 4'd0, 32'h0);
    wait_drained();
    guess_len = 0;

    // Random phases, alternating bursts that fill the list and bursts that drain it.
    for (ph = 0; ph < 4; ph++) begin
      idle_pct = phase_idle[ph];
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if ((n / BURST_LEN) % 2 == 0) queue_random(60, 10);
        else queue_random(10, 60);
      end
      wait_drained();
    end

    repeat (6) @(posedge clk);
    if (!failed && result_queue.size() == 0) begin
      $display("** bounded_array_list_core: PASSED **");
    end else begin
      $display("** bounded_array_list_core: FAILED **");
    end
    $finish;
  end

endmodule
